// ----- src/elsw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsw_pkg
// Shared types and constants of the learning switch core: table geometry,
// scan token, table write request, status and register codes.
// ----------------------------------------------------------------------------
package elsw_pkg;

  localparam int NUM_PORTS     = 8;
  localparam int TABLE_ENTRIES = 64;

  localparam int MAC_W  = 48;
  localparam int SPORT_W = 4;
  localparam int MASK_W = 8;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int GROUP_BIT = 40;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 8;

  // ports that exist and fit in the mask
  localparam logic [MASK_W-1:0] ALL_PORTS_MASK =
    (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NUM_PORTS) - 64'd1);

  typedef enum logic [0:0] {
    REG_HUB_MODE     = 1'b0,
    REG_PORT_ENABLED = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    LS_UNCHANGED   = 3'd0,
    LS_INSERTED    = 3'd1,
    LS_MOVED       = 3'd2,
    LS_FULL        = 3'd3,
    LS_NOT_LEARNED = 3'd4
  } learn_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // search token walking the row of table cells
  typedef struct packed {
    logic              active;
    logic [IDX_W-1:0]  pos;
    logic              src_hit;
    logic [IDX_W-1:0]  src_idx;
    logic [PORT_W-1:0] src_port;
    logic              free_hit;
    logic [IDX_W-1:0]  free_idx;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } wr_req_t;

endpackage

// ----- src/elsw_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsw_cell
// One address table entry. Compares the broadcast keys against its entry
// when the search token passes and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module elsw_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [elsw_pkg::MAC_W-1:0]    src_key,
  input  logic [elsw_pkg::MAC_W-1:0]    dst_key,
  input  elsw_pkg::tok_t                tok_in,
  output elsw_pkg::tok_t                tok_out,
  input  logic                          wr_en,
  input  logic [elsw_pkg::MAC_W-1:0]    wr_mac,
  input  logic [elsw_pkg::PORT_W-1:0]   wr_port
);
  import elsw_pkg::*;

  logic              valid_r;
  logic [MAC_W-1:0]  mac_r;
  logic [PORT_W-1:0] port_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              src_match;
  logic              dst_match;

  assign src_match = valid_r && (mac_r == src_key);
  assign dst_match = valid_r && (mac_r == dst_key);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active) begin
      tok_nxt.pos = tok_in.pos + IDX_W'(1);
      if (src_match && !tok_in.src_hit) begin
        tok_nxt.src_hit  = 1'b1;
        tok_nxt.src_idx  = tok_in.pos;
        tok_nxt.src_port = port_r;
      end
      // lowest free entry wins
      if (!valid_r && !tok_in.free_hit) begin
        tok_nxt.free_hit = 1'b1;
        tok_nxt.free_idx = tok_in.pos;
      end
      if (dst_match && !tok_in.dst_hit) begin
        tok_nxt.dst_hit  = 1'b1;
        tok_nxt.dst_port = port_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_en) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mac_r  <= wr_mac;
      port_r <= wr_port;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- src/elsw_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsw_chain
// Row of table cells with the search token passed one cell per cycle and
// the write request decoded to the addressed cell.
// ----------------------------------------------------------------------------
module elsw_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [elsw_pkg::MAC_W-1:0]    src_key,
  input  logic [elsw_pkg::MAC_W-1:0]    dst_key,
  input  elsw_pkg::tok_t                tok_head,
  output elsw_pkg::tok_t                tok_tail,
  input  elsw_pkg::wr_req_t             wr
);
  import elsw_pkg::*;

  tok_t tok_w [0:TABLE_ENTRIES];

  assign tok_w[0] = tok_head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic wr_en;
    assign wr_en = wr.en && (wr.idx == IDX_W'(i));

    elsw_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .src_key (src_key),
      .dst_key (dst_key),
      .tok_in  (tok_w[i]),
      .tok_out (tok_w[i+1]),
      .wr_en   (wr_en),
      .wr_mac  (wr.mac),
      .wr_port (wr.port)
    );
  end

  assign tok_tail = tok_w[TABLE_ENTRIES];

endmodule

// ----- src/ethernet_learning_switch_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_learning_switch_core
// Learning bridge address table: learns source addresses, looks up the
// destination and returns a forward mask with the learn status.
// ----------------------------------------------------------------------------
// a single item is in flight: in_tready is high only in the idle state, so the
//   next item is taken only once the search token has walked the row of table
//   cells one cell per clock and the result has been registered
// the next item is taken while the previous result still waits on out_tready
// reset (synchronous, rst_n low): all table entries invalid, hub_mode and
//   port_enabled cleared, channels empty
module ethernet_learning_switch_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: src_port[3:0], src_mac[51:4], dst_mac[99:52], zero fill
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [elsw_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: forward_mask[7:0], flooded[8], learn_status[11:9], zero fill
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [elsw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [0:0]                            cfg_index,
  input  logic [elsw_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import elsw_pkg::*;

  state_t             state_r;
  state_t             state_nxt;
  logic               accept;
  logic               finish;

  logic               hub_r;
  logic [MASK_W-1:0]  pen_r;

  logic [SPORT_W-1:0] sport_r;
  logic [MAC_W-1:0]   src_r;
  logic [MAC_W-1:0]   dst_r;
  logic               start_r;
  tok_t               head;
  tok_t               tail;
  tok_t               sum_r;
  wr_req_t            wr;

  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic               has_port;
  logic [PORT_W-1:0]  port;
  logic               learned;
  logic               dst_known;
  logic [PORT_W-1:0]  dst_port;
  learn_status_t      status;
  logic [MASK_W-1:0]  mask;
  logic               flooded;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hub_r <= 1'b0;
      pen_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_HUB_MODE:     hub_r <= cfg_data[0];
        REG_PORT_ENABLED: pen_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: if (tail.active) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready = 1'b0;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DONE: finish = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sport_r <= in_tdata[3:0];
      src_r   <= in_tdata[51:4];
      dst_r   <= in_tdata[99:52];
    end
    if (state_r == ST_SCAN && tail.active) begin
      sum_r <= tail;
    end
  end

  always_comb begin
    head        = '0;
    head.active = start_r;
  end

  elsw_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .src_key  (src_r),
    .dst_key  (dst_r),
    .tok_head (head),
    .tok_tail (tail),
    .wr       (wr)
  );

  // learn decision and forwarding, evaluated once the scan summary is held
  assign has_port = (32'(sport_r) < NUM_PORTS);
  assign port     = PORT_W'(sport_r);

  always_comb begin
    wr      = '0;
    wr.mac  = src_r;
    wr.port = port;
    if (!has_port || src_r[GROUP_BIT]) begin
      status = LS_NOT_LEARNED;
    end else if (sum_r.src_hit) begin
      if (sum_r.src_port == port) begin
        status = LS_UNCHANGED;
      end else begin
        status = LS_MOVED;
        wr.en  = finish;
        wr.idx = sum_r.src_idx;
      end
    end else if (sum_r.free_hit) begin
      status = LS_INSERTED;
      wr.en  = finish;
      wr.idx = sum_r.free_idx;
    end else begin
      status = LS_FULL;
    end
  end

  // destination equal to a source just learned sees the new port
  assign learned = (status == LS_UNCHANGED) || (status == LS_INSERTED) ||
                   (status == LS_MOVED);

  always_comb begin
    dst_known = sum_r.dst_hit;
    dst_port  = sum_r.dst_port;
    if (learned && (src_r == dst_r)) begin
      dst_known = 1'b1;
      dst_port  = port;
    end
    if (dst_r[GROUP_BIT]) begin
      dst_known = 1'b0;
    end
  end

  always_comb begin
    mask    = '0;
    flooded = 1'b0;
    if (!dst_known || hub_r) begin
      mask    = pen_r & ALL_PORTS_MASK;
      if (has_port) begin
        mask = mask & ~(MASK_W'(1) << sport_r);
      end
      flooded = 1'b1;
    end else if (has_port && dst_port == port) begin
      mask = '0;
    end else begin
      mask = (MASK_W'(1) << dst_port) & ALL_PORTS_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {4'b0000, status, flooded, mask};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- bench/ethernet_learning_switch_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_learning_switch_core_tb
// Self-checking bench for the learning switch core. Frame headers are fed
// from a queue with random gaps and receiver stalls. A local copy of the
// address table predicts the forward mask, flood flag and learn status of
// every header, and results are checked in order against that prediction.
// ----------------------------------------------------------------------------
module ethernet_learning_switch_core_tb;
  import elsw_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 800000;
  localparam int POOL_SIZE   = 96;
  localparam int PHASE_ITEMS = 180;
  localparam int NUM_PHASES  = 8;

  typedef struct {
    logic [SPORT_W-1:0] port;
    logic [MAC_W-1:0]   src;
    logic [MAC_W-1:0]   dst;
  } hdr_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              flooded;
    learn_status_t     status;
  } fwd_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // in_tdata: src_port[3:0], src_mac[51:4], dst_mac[99:52], zero fill
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: forward_mask[7:0], flooded[8], learn_status[11:9], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index = REG_HUB_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the address table and registers
  bit                 tbl_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]   tbl_mac   [TABLE_ENTRIES];
  logic [SPORT_W-1:0] tbl_port  [TABLE_ENTRIES];
  logic               hub_mode = 1'b0;
  logic [MASK_W-1:0]  port_enabled = '0;

  hdr_t pending_hdrs[$];
  fwd_t expected_fwd[$];
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  int   gap_max = 7;
  int   in_gap = 0;
  bit   in_gap_on_ready = 1'b0;
  int   out_stall = 0;
  bit   out_stall_always = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;

  int cycles = 0;
  int hdrs_sent = 0;
  int items_in = 0;
  int results_out = 0;
  int err_count = 0;
  int status_seen [5];
  int n_flood = 0;
  int n_direct = 0;
  int n_filtered = 0;

  ethernet_learning_switch_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int find_mac(logic [MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  // learns the source, then picks the egress ports for the destination
  function automatic fwd_t forward_lookup(hdr_t h);
    fwd_t r;
    int   hit;
    int   slot;
    logic has_port;
    r.mask = '0;
    r.flooded = 1'b0;
    r.status = LS_NOT_LEARNED;
    has_port = (h.port < NUM_PORTS);
    if (has_port && !h.src[GROUP_BIT]) begin
      hit = find_mac(h.src);
      if (hit >= 0) begin
        r.status = (tbl_port[hit] == h.port) ? LS_UNCHANGED : LS_MOVED;
        tbl_port[hit] = h.port;
      end else begin
        slot = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
          if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          r.status = LS_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_mac[slot] = h.src;
          tbl_port[slot] = h.port;
          r.status = LS_INSERTED;
        end
      end
    end
    hit = h.dst[GROUP_BIT] ? -1 : find_mac(h.dst);
    if (hit < 0 || hub_mode) begin
      r.mask = port_enabled & ALL_PORTS_MASK;
      if (has_port && h.port < MASK_W) r.mask[h.port] = 1'b0;
      r.flooded = 1'b1;
    end else if (!(has_port && tbl_port[hit] == h.port) && tbl_port[hit] < MASK_W) begin
      // learned port wins even when it is not enabled for floods
      r.mask = ALL_PORTS_MASK & (MASK_W'(1) << tbl_port[hit]);
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac(int lim);
    if ($urandom_range(0, 15) == 0) return MAC_W'({$urandom(), $urandom()});
    return mac_pool[$urandom_range(0, lim - 1)];
  endfunction

  function automatic hdr_t rand_hdr(int lim);
    hdr_t h;
    int   pick;
    if ($urandom_range(0, 7) == 0) h.port = SPORT_W'($urandom_range(NUM_PORTS, 15));
    else h.port = SPORT_W'($urandom_range(0, NUM_PORTS - 1));
    h.src = pick_mac(lim);
    pick = $urandom_range(0, 9);
    if (pick == 0) h.dst = '1;
    else if (pick == 1) h.dst = pick_mac(POOL_SIZE) | (MAC_W'(1) << GROUP_BIT);
    else h.dst = pick_mac((lim + 8 > POOL_SIZE) ? POOL_SIZE : lim + 8);
    return h;
  endfunction

  task automatic send(logic [SPORT_W-1:0] port, logic [MAC_W-1:0] src,
                      logic [MAC_W-1:0] dst);
    hdr_t h;
    h.port = port;
    h.src = src;
    h.dst = dst;
    pending_hdrs.push_back(h);
  endtask

  // block is idle once every header handed to the driver has its result
  task automatic drain();
    while (pending_hdrs.size() != 0 || results_out < hdrs_sent) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HUB_MODE) hub_mode = val[0];
    else port_enabled = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(negedge clk) begin : feed_headers
    hdr_t h;
    logic vld;
    vld = in_tvalid;
    if (in_took) begin
      vld = 1'b0;
      in_gap = $urandom_range(0, gap_max);
      in_gap_on_ready = $urandom_range(0, 1);
    end
    if (rst_n && !vld) begin
      if (in_gap > 0) begin
        // half the gaps only count while the core could take an item
        if (!in_gap_on_ready || in_tready) in_gap--;
      end else if (pending_hdrs.size() != 0) begin
        h = pending_hdrs.pop_front();
        hdrs_sent++;
        in_tdata <= IN_TDATA_W'({h.dst, h.src, h.port});
        vld = 1'b1;
      end
    end
    in_tvalid <= vld;
  end

  always @(negedge clk) begin : take_results
    if (out_took) begin
      out_stall = $urandom_range(0, gap_max);
      out_stall_always = $urandom_range(0, 1);
    end else if (out_stall > 0 && (out_stall_always || out_tvalid)) begin
      out_stall--;
    end
    out_tready <= rst_n && !rx_hold && out_stall == 0;
  end

  always begin : long_receiver_hold
    wait (hold_req);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
    wait (!hold_req);
  end

  always @(posedge clk) begin : check_results
    hdr_t h;
    fwd_t want;
    fwd_t got;
    cycles++;
    in_took <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      h.port = in_tdata[SPORT_W-1:0];
      h.src = in_tdata[SPORT_W +: MAC_W];
      h.dst = in_tdata[SPORT_W + MAC_W +: MAC_W];
      want = forward_lookup(h);
      expected_fwd.push_back(want);
      items_in++;
      status_seen[want.status]++;
      if (want.flooded) n_flood++;
      else if (want.mask == '0) n_filtered++;
      else n_direct++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.mask = out_tdata[MASK_W-1:0];
      got.flooded = out_tdata[MASK_W];
      got.status = learn_status_t'(out_tdata[MASK_W+1 +: 3]);
      results_out++;
      if (expected_fwd.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_out));
      end else begin
        want = expected_fwd.pop_front();
        if (got.mask !== want.mask)
          report_error($sformatf("result %0d forward_mask %02h, expected %02h",
                                 results_out, got.mask, want.mask));
        if (got.flooded !== want.flooded)
          report_error($sformatf("result %0d flooded %b, expected %b",
                                 results_out, got.flooded, want.flooded));
        if (got.status !== want.status)
          report_error($sformatf("result %0d learn_status %0d, expected %0d",
                                 results_out, got.status, want.status));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, expected_fwd.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [MAC_W-1:0]      mac_a;
    logic [MAC_W-1:0]      mac_b;
    logic [MAC_W-1:0]      mac_c;
    logic                  ph_hub;
    logic [CFG_DATA_W-1:0] ph_en;
    int                    ph_pool;
    for (int i = 0; i < POOL_SIZE; i++) begin
      mac_pool[i] = MAC_W'({$urandom(), $urandom()});
      // every tenth address is a group address
      mac_pool[i][GROUP_BIT] = (i % 10 == 9);
    end
    mac_a = mac_pool[0];
    mac_b = mac_pool[1];
    mac_c = mac_pool[2];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: no port takes floods
    send(4'd0, mac_a, '1);
    send(4'd3, mac_b, mac_a);
    drain();
    write_reg(REG_PORT_ENABLED, 8'hFF);
    write_reg(REG_HUB_MODE, 8'h00);
    send(4'd0, mac_a, mac_a);
    send(4'd5, mac_a, mac_b);
    send(4'd8, mac_c, 48'h0000_0000_0001);
    send(4'd15, mac_c | (MAC_W'(1) << GROUP_BIT), mac_b);
    send(4'd2, 48'h0100_0000_0000, 48'h0100_0000_0000);
    send(4'd7, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF);
    send(4'd1, 48'hFEFF_FFFF_FFFF, 48'h0000_0000_0000);
    send(4'd6, 48'hFFFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFF);
    send(4'd4, mac_b, mac_c);
    send(4'd9, mac_a, mac_a);
    drain();
    // ports 1, 3, 4 and 6 left out of the flood set
    write_reg(REG_PORT_ENABLED, 8'hA5);
    send(4'd0, mac_c, mac_b);
    send(4'd1, mac_b, mac_pool[5]);
    drain();
    write_reg(REG_HUB_MODE, 8'h01);
    send(4'd0, mac_a, mac_b);
    send(4'd4, mac_b, mac_b);
    send(4'd8, mac_pool[3], '1);
    drain();

    // address pool grows phase by phase so the table fills part way through
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      ph_hub = 1'b0;
      ph_en = 8'hFF;
      ph_pool = POOL_SIZE;
      gap_max = 7;
      case (ph)
        0: ph_pool = 24;
        1: begin
          ph_en = 8'h00;
          ph_pool = 40;
          gap_max = 0;
        end
        2: begin
          ph_hub = 1'b1;
          ph_en = CFG_DATA_W'($urandom_range(0, 255));
          ph_pool = 48;
        end
        3: begin
          ph_en = CFG_DATA_W'($urandom_range(0, 255));
          ph_pool = 64;
        end
        4: begin
          ph_pool = 80;
          gap_max = 0;
        end
        5: ph_hub = 1'b1;
        6: ph_en = 8'h80;
        default: ph_en = CFG_DATA_W'($urandom_range(0, 255));
      endcase
      write_reg(REG_HUB_MODE, CFG_DATA_W'(ph_hub));
      write_reg(REG_PORT_ENABLED, ph_en);
      if (ph == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) pending_hdrs.push_back(rand_hdr(ph_pool));
      drain();
      hold_req = 1'b0;
    end

    drain();
    repeat (TABLE_ENTRIES + 16) @(posedge clk);
    $display("covered %0d headers: %0d inserted, %0d moved, %0d unchanged, %0d table full, %0d not learned",
             items_in, status_seen[LS_INSERTED], status_seen[LS_MOVED],
             status_seen[LS_UNCHANGED], status_seen[LS_FULL], status_seen[LS_NOT_LEARNED]);
    $display("forwarding: %0d flooded, %0d to a learned port, %0d filtered; %0d mismatches",
             n_flood, n_direct, n_filtered, err_count);
    if (err_count == 0 && expected_fwd.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
